// File: src/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Request and status codes, the control bundle broadcast to every cell,
// and the default capacity.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int WORD_W           = 32;
	localparam int DEFAULT_CAPACITY = 64;

	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_BACK   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Broadcast to every cell of the row in the cycle a request is applied.
	typedef struct packed {
		logic              en;
		req_t              req;
		logic [WORD_W-1:0] value;
	} cell_ctrl_t;

endpackage

// File: src/dq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue row
// Holds one word and an occupied flag; moves its word to or from its neighbors
// at a push or pop at the front, and takes or drops the word at the back.
// ----------------------------------------------------------------------------
module dq_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dq_pkg::cell_ctrl_t        ctrl,
	input  logic                      left_valid,
	input  logic [dq_pkg::WORD_W-1:0] left_data,
	input  logic                      right_valid,
	input  logic [dq_pkg::WORD_W-1:0] right_data,
	output logic                      valid,
	output logic [dq_pkg::WORD_W-1:0] data,
	output logic [dq_pkg::WORD_W-1:0] tail_data
);

	logic                      valid_q;
	logic [dq_pkg::WORD_W-1:0] data_q;

	// The queue stays packed toward cell 0, so the occupied flags form a
	// thermometer code and each cell finds the back end from its neighbors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.en) begin
			unique case (ctrl.req)
				dq_pkg::REQ_PUSH_FRONT: valid_q <= left_valid;
				dq_pkg::REQ_PUSH_BACK:  valid_q <= valid_q | left_valid;
				dq_pkg::REQ_POP_FRONT:  valid_q <= right_valid;
				dq_pkg::REQ_POP_BACK:   valid_q <= valid_q & right_valid;
				default:                valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			unique case (ctrl.req)
				dq_pkg::REQ_PUSH_FRONT: data_q <= left_data;
				dq_pkg::REQ_PUSH_BACK: begin
					if (left_valid && !valid_q) data_q <= ctrl.value;
				end
				dq_pkg::REQ_POP_FRONT:  data_q <= right_data;
				default:                data_q <= data_q;
			endcase
		end
	end

	assign valid     = valid_q;
	assign data      = data_q;
	assign tail_data = (valid_q && !right_valid) ? data_q : '0;

endmodule

// File: src/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of signed words
// A row of CAPACITY cells holds the words packed from the front; every
// transaction pushes or pops at either end and reports one result.
// ----------------------------------------------------------------------------
// A transaction is taken at each rising edge with start high; busy is never
// raised, so a new transaction can follow in every cycle. Its result appears
// on the next cycle with done high for exactly that cycle, and the receiver
// cannot stall it. The result is registered straight from the cell row, which
// shifts or writes all cells in the same edge, and from the one-hot selection
// of the back word across the row for a pop at the back. A push to a full
// queue or a pop from an empty one changes nothing and reports overflow or
// underflow with a zero pop_value.
module double_ended_queue #(
	parameter int CAPACITY = dq_pkg::DEFAULT_CAPACITY,
	localparam int CntW    = $clog2(CAPACITY + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       req_type,
	input  logic signed [dq_pkg::WORD_W-1:0] push_value,
	output logic                             done,
	output logic signed [dq_pkg::WORD_W-1:0] pop_value,
	output logic [1:0]                       status,
	output logic [CntW-1:0]                  fill_count
);

	dq_pkg::req_t       req;
	dq_pkg::cell_ctrl_t ctrl;
	dq_pkg::status_t    status_d;

	logic                      cell_valid [CAPACITY];
	logic [dq_pkg::WORD_W-1:0] cell_data  [CAPACITY];
	logic [dq_pkg::WORD_W-1:0] cell_tail  [CAPACITY];

	logic [CntW-1:0]           count_q;
	logic [CntW-1:0]           count_d;
	logic                      accept;
	logic                      full;
	logic                      empty;
	logic                      is_push;
	logic                      fail;
	logic [dq_pkg::WORD_W-1:0] back_word;
	logic [dq_pkg::WORD_W-1:0] pop_d;

	logic                      done_q;
	logic [dq_pkg::WORD_W-1:0] pop_value_q;
	logic [1:0]                status_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign req    = dq_pkg::req_t'(req_type);

	assign full    = (count_q == CntW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign is_push = (req == dq_pkg::REQ_PUSH_FRONT) || (req == dq_pkg::REQ_PUSH_BACK);
	assign fail    = is_push ? full : empty;

	assign ctrl.en    = accept && !fail;
	assign ctrl.req   = req;
	assign ctrl.value = push_value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                      lv;
		logic [dq_pkg::WORD_W-1:0] ld;
		logic                      rv;
		logic [dq_pkg::WORD_W-1:0] rd;

		// The new front word enters the row from the left of cell 0.
		if (i == 0) begin : g_first
			assign lv = 1'b1;
			assign ld = push_value;
		end else begin : g_inner_l
			assign lv = cell_valid[i-1];
			assign ld = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_inner_r
			assign rv = cell_valid[i+1];
			assign rd = cell_data[i+1];
		end

		dq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_valid  (lv),
			.left_data   (ld),
			.right_valid (rv),
			.right_data  (rd),
			.valid       (cell_valid[i]),
			.data        (cell_data[i]),
			.tail_data   (cell_tail[i])
		);
	end

	// Only the last occupied cell drives a nonzero tail word.
	always_comb begin
		back_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_word = back_word | cell_tail[i];
		end
	end

	always_comb begin
		status_d = dq_pkg::ST_OK;
		pop_d    = '0;
		count_d  = count_q;
		if (fail) begin
			status_d = is_push ? dq_pkg::ST_OVERFLOW : dq_pkg::ST_UNDERFLOW;
		end else if (is_push) begin
			count_d = count_q + CntW'(1);
		end else begin
			count_d = count_q - CntW'(1);
			pop_d   = (req == dq_pkg::REQ_POP_FRONT) ? cell_data[0] : back_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_value_q <= pop_d;
			status_q    <= status_d;
		end
	end

	assign done       = done_q;
	assign pop_value  = pop_value_q;
	assign status     = status_q;
	assign fill_count = count_q;

endmodule
